// ===== design/fraction_reduce_compare_top_assert.svh =====
// Assertion macros for the fraction reduce and compare block
`ifndef FRACTION_REDUCE_COMPARE_TOP_ASSERT_SVH
`define FRACTION_REDUCE_COMPARE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FRC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define FRC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/frc_pkg.sv =====
// Package: constants and types for the fraction reduce and compare block
`default_nettype none
package frc_pkg;
   localparam int WordBitsDefault = 32;
   localparam int FieldBits = 32;
   localparam int DenBits = 31;
endpackage
`default_nettype wire

// ===== design/frc_divider.sv =====
// Bit-serial restoring divider: quotient and remainder of two unsigned words
`default_nettype none
module frc_divider #(
   parameter int WordBits = frc_pkg::WordBitsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [WordBits-1:0] dividend,
   input  wire logic [WordBits-1:0] divisor,
   output logic                     done,
   output logic [WordBits-1:0]      quotient,
   output logic [WordBits-1:0]      remainder
);
   import frc_pkg::*;
   localparam int CntBits = $clog2(WordBits + 1);

   logic                busy_ff, busy_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [WordBits-1:0] quo_ff, quo_in;
   logic [WordBits-1:0] rem_ff, rem_in;
   logic [WordBits-1:0] dvs_ff, dvs_in;
   logic                done_ff, done_in;
   logic [WordBits:0]   trial;
   logic [WordBits:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WordBits-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(WordBits);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         if (!diff[WordBits]) begin
            rem_in = diff[WordBits-1:0];
            quo_in = {quo_ff[WordBits-2:0], 1'b1};
         end else begin
            rem_in = trial[WordBits-1:0];
            quo_in = {quo_ff[WordBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== design/frc_multiplier.sv =====
// Bit-serial shift-and-add multiplier: full double-width unsigned product
`default_nettype none
module frc_multiplier #(
   parameter int WordBits = frc_pkg::WordBitsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [WordBits-1:0]   op_x,
   input  wire logic [WordBits-1:0]   op_y,
   output logic                       done,
   output logic [2*WordBits-1:0]      product
);
   import frc_pkg::*;
   localparam int CntBits = $clog2(WordBits + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic [WordBits-1:0]   mcand_ff, mcand_in;
   logic [2*WordBits-1:0] acc_ff, acc_in;
   logic [WordBits:0]     upper;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      upper    = {1'b0, acc_ff[2*WordBits-1:WordBits]}
                 + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CntBits'(WordBits);
         mcand_in = op_x;
         acc_in   = {{WordBits{1'b0}}, op_y};
      end else if (busy_ff) begin
         // add in the multiplicand on the low bit, then shift right
         acc_in = {upper, acc_ff[WordBits-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ===== design/fraction_reduce_compare_top.sv =====
// Top level: reduces two fractions by GCD and returns the larger one, or flags a zero denominator
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | num_a den_a num_b den_b
//  rsp     | out       | rsp_valid/rsp_stall | result_num result_den first_chosen
//                                                zero_den_error
//
// One item at a time. Each GCD step, each of the four exact divisions and each
// of the two cross products is one serial pass through the divider or the
// multiplier. rsp_valid rises once the second cross product is done; a zero
// denominator is offered the cycle after acceptance. Reset is synchronous;
// a stalled result holds in the output register, and no new item is taken
// until it goes.
`default_nettype none
module fraction_reduce_compare_top #(
   parameter int WordBits = frc_pkg::WordBitsDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [frc_pkg::FieldBits-1:0]  req_num_a,
   input  wire logic signed [frc_pkg::FieldBits-1:0]  req_den_a,
   input  wire logic signed [frc_pkg::FieldBits-1:0]  req_num_b,
   input  wire logic signed [frc_pkg::FieldBits-1:0]  req_den_b,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [frc_pkg::FieldBits-1:0]       rsp_result_num,
   output logic [frc_pkg::DenBits-1:0]                rsp_result_den,
   output logic                                       rsp_first_chosen,
   output logic                                       rsp_zero_den_error
);
   import frc_pkg::*;
   `include "fraction_reduce_compare_top_assert.svh"

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StGcdGo  = 4'd1;
   localparam logic [3:0] StGcdWt  = 4'd2;
   localparam logic [3:0] StDivNGo = 4'd3;
   localparam logic [3:0] StDivNWt = 4'd4;
   localparam logic [3:0] StDivDGo = 4'd5;
   localparam logic [3:0] StDivDWt = 4'd6;
   localparam logic [3:0] StMul1Go = 4'd7;
   localparam logic [3:0] StMul1Wt = 4'd8;
   localparam logic [3:0] StMul2Go = 4'd9;
   localparam logic [3:0] StMul2Wt = 4'd10;
   localparam logic [3:0] StOut    = 4'd11;

   localparam logic [WordBits-1:0] TopBit = {1'b1, {(WordBits-1){1'b0}}};
   localparam logic [WordBits-1:0] MaxMag = ~TopBit;

   function automatic logic [WordBits-1:0] sat_mag(input logic [FieldBits-1:0] raw);
      logic [WordBits-1:0] v;
      logic [WordBits-1:0] a;
      v = raw[WordBits-1:0];
      a = ~v + 1'b1;
      if (!v[WordBits-1]) return v;
      if (a > MaxMag) return MaxMag;
      return a;
   endfunction

   logic [3:0]            state_ff, state_in;
   logic                  side_ff, side_in;    // 0: fraction a, 1: fraction b
   logic [WordBits-1:0]   nm_ff [2];
   logic [WordBits-1:0]   dm_ff [2];
   logic [WordBits-1:0]   nm_in [2];
   logic [WordBits-1:0]   dm_in [2];
   logic [1:0]            sgn_ff, sgn_in;      // operand sign differs per fraction
   logic [WordBits-1:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic [2*WordBits-1:0] p1_ff, p1_in;
   logic                  rv_ff, rv_in;
   logic [FieldBits-1:0]  rn_ff, rn_in;
   logic [DenBits-1:0]    rd_ff, rd_in;
   logic                  rf_ff, rf_in;
   logic                  re_ff, re_in;

   logic                  div_start, div_done;
   logic [WordBits-1:0]   div_a, div_b, div_q, div_r;
   logic                  mul_start, mul_done;
   logic [WordBits-1:0]   mul_x, mul_y;
   logic [2*WordBits-1:0] mul_p;

   logic                  accept;
   logic [WordBits-1:0]   ma, ea, mb, eb;
   logic                  ra, rb, first;
   logic [WordBits-1:0]   sel_n, sel_d, neg_n;

   frc_divider #(.WordBits(WordBits)) u_div (
      .clock, .reset, .start(div_start), .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   frc_multiplier #(.WordBits(WordBits)) u_mul (
      .clock, .reset, .start(mul_start), .op_x(mul_x), .op_y(mul_y),
      .done(mul_done), .product(mul_p)
   );

   assign req_stall = (state_ff != StIdle) || rv_ff;
   assign accept    = req_valid && !req_stall;

   assign ma = sat_mag(req_num_a);
   assign ea = sat_mag(req_den_a);
   assign mb = sat_mag(req_num_b);
   assign eb = sat_mag(req_den_b);

   assign ra = sgn_ff[0] && (nm_ff[0] != '0);
   assign rb = sgn_ff[1] && (nm_ff[1] != '0);

   always_comb begin
      state_in  = state_ff;
      side_in   = side_ff;
      nm_in     = nm_ff;
      dm_in     = dm_ff;
      sgn_in    = sgn_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      p1_in     = p1_ff;
      rv_in     = rv_ff && rsp_stall;
      rn_in     = rn_ff;
      rd_in     = rd_ff;
      rf_in     = rf_ff;
      re_in     = re_ff;
      div_start = 1'b0;
      div_a     = gx_ff;
      div_b     = gy_ff;
      mul_start = 1'b0;
      mul_x     = nm_ff[0];
      mul_y     = dm_ff[1];
      first     = 1'b0;
      sel_n     = '0;
      sel_d     = '0;
      neg_n     = '0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               nm_in[0] = ma;
               dm_in[0] = ea;
               nm_in[1] = mb;
               dm_in[1] = eb;
               sgn_in   = {req_num_b[WordBits-1] ^ req_den_b[WordBits-1],
                           req_num_a[WordBits-1] ^ req_den_a[WordBits-1]};
               side_in  = 1'b0;
               gx_in    = ma;
               gy_in    = ea;
               if (ea == '0 || eb == '0) begin
                  rv_in = 1'b1;
                  rn_in = '0;
                  rd_in = '0;
                  rf_in = 1'b0;
                  re_in = 1'b1;
               end else begin
                  state_in = StGcdGo;
               end
            end
         end
         StGcdGo: begin
            // Euclid: one remainder per divider pass; gy never starts at zero
            div_start = 1'b1;
            state_in  = StGcdWt;
         end
         StGcdWt: begin
            if (div_done) begin
               gx_in = gy_ff;
               gy_in = div_r;
               state_in = (div_r == '0) ? StDivNGo : StGcdGo;
            end
         end
         StDivNGo: begin
            // gx holds the gcd, nonzero because the denominator is
            div_start = 1'b1;
            div_a     = nm_ff[side_ff];
            div_b     = gx_ff;
            state_in  = StDivNWt;
         end
         StDivNWt: begin
            if (div_done) begin
               nm_in[side_ff] = div_q;
               state_in = StDivDGo;
            end
         end
         StDivDGo: begin
            div_start = 1'b1;
            div_a     = dm_ff[side_ff];
            div_b     = gx_ff;
            state_in  = StDivDWt;
         end
         StDivDWt: begin
            if (div_done) begin
               dm_in[side_ff] = div_q;
               if (!side_ff) begin
                  side_in  = 1'b1;
                  gx_in    = nm_ff[1];
                  gy_in    = dm_ff[1];
                  state_in = StGcdGo;
               end else begin
                  state_in = StMul1Go;
               end
            end
         end
         StMul1Go: begin
            mul_start = 1'b1;
            state_in  = StMul1Wt;
         end
         StMul1Wt: begin
            if (mul_done) begin
               p1_in    = mul_p;
               state_in = StMul2Go;
            end
         end
         StMul2Go: begin
            mul_start = 1'b1;
            mul_x     = nm_ff[1];
            mul_y     = dm_ff[0];
            state_in  = StMul2Wt;
         end
         StMul2Wt: begin
            mul_x = nm_ff[1];
            mul_y = dm_ff[0];
            if (mul_done) state_in = StOut;
         end
         StOut: begin
            // mul_p still holds the second cross product
            if (ra != rb) first = !ra;
            else if (ra)  first = p1_ff < mul_p;
            else          first = p1_ff > mul_p;
            sel_n = first ? nm_ff[0] : nm_ff[1];
            sel_d = first ? dm_ff[0] : dm_ff[1];
            neg_n = (first ? ra : rb) ? (~sel_n + 1'b1) : sel_n;
            rn_in = FieldBits'(neg_n);
            rd_in = DenBits'(sel_d);
            rf_in = first;
            re_in = 1'b0;
            rv_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      side_ff <= side_in;
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      sgn_ff  <= sgn_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      p1_ff   <= p1_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      rf_ff   <= rf_in;
      re_ff   <= re_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_result_num     = rn_ff;
   assign rsp_result_den     = rd_ff;
   assign rsp_first_chosen   = rf_ff;
   assign rsp_zero_den_error = re_ff;

   `FRC_ASSERT_IMP(a_busy_stalls, state_ff != StIdle, req_stall)
   `FRC_ASSERT_IMP(a_err_clean, rv_ff && re_ff, rn_ff == '0 && rd_ff == '0 && !rf_ff)
   `FRC_ASSERT_IMP(a_den_nonzero, rv_ff && !re_ff, rd_ff != '0)
   `FRC_ASSERT_NEXT(a_held, rv_ff && rsp_stall, rv_ff && $stable(rn_ff))
endmodule
`default_nettype wire
